[sv/htw_pkg.sv]
// shared types and constants for the hashed timer wheel
// no dependencies; imported by htw_div and hashed_timer_wheel_unit
package htw_pkg;

    // operation codes of an input item
    localparam logic [1:0] OP_SCHEDULE = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;
    localparam logic [1:0] OP_QUERY    = 2'd3;

    // result status codes
    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_BAD_ID    = 3'd1;
    localparam logic [2:0] STS_TIME_BACK = 3'd2;
    localparam logic [2:0] STS_JUMP      = 3'd3;
    localparam logic [2:0] STS_NONE      = 3'd4;

    // configuration register indexes
    localparam logic REG_PRECISION = 1'b0;
    localparam logic REG_SLOTS     = 1'b1;

    localparam logic [15:0] PREC_RESET  = 16'd10;
    localparam logic [8:0]  SLOTS_RESET = 9'd256;
    localparam int          JUDGE_FACTOR = 10;

    // shared divider widths
    localparam int DIV_NW = 33;
    localparam int DIV_DW = 16;

    typedef struct packed {
        logic [1:0]  op;
        logic [5:0]  tmr_id;
        logic [31:0] trigger_ms;
        logic [31:0] interval_ms;
        logic [31:0] now_ms;
    } t_in;

    typedef struct packed {
        logic [2:0] status;
        logic       fired;
        logic [5:0] result_id;
        logic [6:0] fired_total;
        logic       last;
    } t_out;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
        logic [DIV_DW-1:0] rem;
    } t_div_rsp;

endpackage

[sv/htw_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/htw_div.sv]
// restoring divider, one quotient bit per cycle
// depends on htw_pkg for widths and request/response types
module htw_div
    import htw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    localparam int CNTW = $clog2(DIV_NW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNTW-1:0]   r_cnt, n_cnt;
    logic [DIV_NW-1:0] r_q, n_q;
    logic [DIV_DW-1:0] r_r, n_r;
    logic [DIV_DW-1:0] r_den, n_den;
    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              ge;

    always_comb begin
        shifted = {r_r, r_q[DIV_NW-1]};
        ge      = shifted >= {1'b0, r_den};
        diff    = shifted - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_q     = r_q;
        n_r     = r_r;
        n_den   = r_den;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_q    = i_req.num;
            n_r    = '0;
            n_den  = i_req.den;
        end else if (r_busy) begin
            n_q = {r_q[DIV_NW-2:0], ge};
            n_r = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
            n_cnt = r_cnt + CNTW'(1);
            if (r_cnt == CNTW'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_r   <= n_r;
        r_den <= n_den;
    end

    assign o_rsp = '{done: r_done, quot: r_q, rem: r_r};
endmodule

[sv/hashed_timer_wheel_unit.sv]
// hashed timer wheel top level: sequencer, link memories, config port
// depends on htw_pkg, htw_ram and htw_div
//
// usage
//   input channel i_in_valid/o_in_ready carries t_in items (schedule, cancel,
//   dispatch, query); output channel o_out_valid/i_out_ready carries t_out
//   results. schedule, cancel and query give one result each. dispatch gives
//   one result per expired timer, last set on the final one, or one result
//   with fired clear when nothing expired or the time check failed.
//   one item is worked at a time: o_in_ready is high only while the sequencer
//   is idle. a hook costs two divides, one for a trigger already past, a query
//   one divide plus a walk over the slots looked at, a dispatch two divides
//   plus a walk over the slots passed, an unhook per timer taken off and a
//   hook per timer put back. all divides go to the shared divider.
//   results go through one output register; while the receiver stalls the
//   sequencer holds at its next result and the register keeps its transfer.
//   after reset the slot head memory is cleared, one entry a cycle over all
//   MAX_SLOTS entries, with o_in_ready low; config writes are taken meanwhile.
//   precision_ms at 0x0 and slots_in_use at 0x4; pready is always high.
module hashed_timer_wheel_unit
    import htw_pkg::*;
#(
    parameter int NUM_TIMERS = 64,
    parameter int MAX_SLOTS  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int IW  = $clog2(NUM_TIMERS);     // timer index
    localparam int PW  = IW + 1;                 // link pointer, msb marks empty
    localparam int SIW = $clog2(MAX_SLOTS);      // slot index
    localparam int SW  = $clog2(MAX_SLOTS + 1);  // slot count
    localparam int CW  = $clog2(NUM_TIMERS + 1); // timer count
    localparam logic [PW-1:0] NIL = {1'b1, {IW{1'b0}}};

    // sequencer states
    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_DEC  = 5'd2;
    localparam logic [4:0] S_EMIT = 5'd3;
    localparam logic [4:0] S_H0   = 5'd4;
    localparam logic [4:0] S_H1   = 5'd5;
    localparam logic [4:0] S_H2   = 5'd6;
    localparam logic [4:0] S_H3   = 5'd7;
    localparam logic [4:0] S_H4   = 5'd8;
    localparam logic [4:0] S_H5   = 5'd9;
    localparam logic [4:0] S_U0   = 5'd10;
    localparam logic [4:0] S_U1   = 5'd11;
    localparam logic [4:0] S_P0   = 5'd12;
    localparam logic [4:0] S_P1   = 5'd13;
    localparam logic [4:0] S_P2   = 5'd14;
    localparam logic [4:0] S_P3   = 5'd15;
    localparam logic [4:0] S_W0   = 5'd16;
    localparam logic [4:0] S_W1   = 5'd17;
    localparam logic [4:0] S_W2   = 5'd18;
    localparam logic [4:0] S_D1   = 5'd19;
    localparam logic [4:0] S_D2   = 5'd20;
    localparam logic [4:0] S_D3   = 5'd21;
    localparam logic [4:0] S_FIN  = 5'd22;
    localparam logic [4:0] S_Q0   = 5'd23;
    localparam logic [4:0] S_Q1   = 5'd24;
    localparam logic [4:0] S_Q2   = 5'd25;

    // control and architectural state
    logic [4:0]          r_state, n_state;
    t_in                 r_in, n_in;
    logic [IW-1:0]       r_cur, n_cur;
    logic [NUM_TIMERS-1:0] r_active, n_active;
    logic [31:0]         r_base, n_base;
    logic [SIW-1:0]      r_start, n_start;
    logic [15:0]         r_prec;
    logic [8:0]          r_slots;
    logic [SIW-1:0]      r_clr, n_clr;
    t_out                r_res, n_res;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    // per-item working registers
    logic [SIW-1:0]      r_s, n_s;
    logic [PW-1:0]       r_n, n_n;
    logic [SIW-1:0]      r_ws, n_ws;
    logic [SIW-1:0]      r_i, n_i;
    logic [SIW-1:0]      r_passing, n_passing;
    logic [SIW-1:0]      r_start0, n_start0;
    logic [SW+15:0]      r_len, n_len;
    logic [32:0]         r_limit, n_limit;
    logic [31:0]         r_t, n_t;
    logic [31:0]         r_iv, n_iv;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_ndef, n_ndef;
    logic [CW-1:0]       r_d, n_d;
    logic                r_has_pend, n_has_pend;
    logic [IW-1:0]       r_pend_id, n_pend_id;

    // memory ports
    logic                head_we;
    logic [SIW-1:0]      head_waddr, head_raddr;
    logic [PW-1:0]       head_wdata, head_rdata;
    logic                next_we;
    logic [IW-1:0]       next_waddr;
    logic [PW-1:0]       next_wdata, next_rdata;
    logic                prev_we;
    logic [IW-1:0]       prev_waddr;
    logic [PW-1:0]       prev_wdata, prev_rdata;
    logic                slot_we;
    logic [SIW-1:0]      slot_wdata, slot_rdata;
    logic                trig_we;
    logic [31:0]         trig_wdata, trig_rdata;
    logic                ival_we;
    logic [31:0]         ival_rdata;
    logic                defer_we;
    logic [IW-1:0]       defer_rdata;

    t_div_req            div_req;
    t_div_rsp            div_rsp;

    // effective configuration
    logic [15:0]         prec_e;
    logic [SW-1:0]       slots_e;
    logic                out_free;
    logic                cfg_wr;

    // scratch
    logic [31:0]         elapsed;
    logic [SW-1:0]       ws_inc;
    logic [SW:0]         start_sum;
    logic [31:0]         iv_eff;
    logic [32:0]         rearm;
    logic [SIW+15:0]     step_ms;
    logic                id_bad;

    assign prec_e   = (r_prec == 16'd0) ? 16'd1 : r_prec;
    assign out_free = !r_out_valid || i_out_ready;
    assign cfg_wr   = psel && penable && pwrite;

    always_comb begin
        if (32'(r_slots) < 32'd2) begin
            slots_e = SW'(2);
        end else if (32'(r_slots) > 32'(MAX_SLOTS)) begin
            slots_e = SW'(MAX_SLOTS);
        end else begin
            slots_e = SW'(r_slots);
        end
    end

    htw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    htw_ram #(.WIDTH(PW), .DEPTH(MAX_SLOTS)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    htw_ram #(.WIDTH(PW), .DEPTH(NUM_TIMERS)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(r_cur), .o_rdata(next_rdata)
    );
    htw_ram #(.WIDTH(PW), .DEPTH(NUM_TIMERS)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_raddr(r_cur), .o_rdata(prev_rdata)
    );
    htw_ram #(.WIDTH(SIW), .DEPTH(NUM_TIMERS)) u_slot (
        .i_clk(i_clk), .i_we(slot_we), .i_waddr(r_cur), .i_wdata(slot_wdata),
        .i_raddr(r_cur), .o_rdata(slot_rdata)
    );
    htw_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_trig (
        .i_clk(i_clk), .i_we(trig_we), .i_waddr(r_cur), .i_wdata(trig_wdata),
        .i_raddr(r_cur), .o_rdata(trig_rdata)
    );
    htw_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_ival (
        .i_clk(i_clk), .i_we(ival_we), .i_waddr(r_cur), .i_wdata(r_in.interval_ms),
        .i_raddr(r_cur), .o_rdata(ival_rdata)
    );
    htw_ram #(.WIDTH(IW), .DEPTH(NUM_TIMERS)) u_defer (
        .i_clk(i_clk), .i_we(defer_we), .i_waddr(r_ndef[IW-1:0]), .i_wdata(r_cur),
        .i_raddr(r_d[IW-1:0]), .o_rdata(defer_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_in        = r_in;
        n_cur       = r_cur;
        n_active    = r_active;
        n_base      = r_base;
        n_start     = r_start;
        n_clr       = r_clr;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_s         = r_s;
        n_n         = r_n;
        n_ws        = r_ws;
        n_i         = r_i;
        n_passing   = r_passing;
        n_start0    = r_start0;
        n_len       = r_len;
        n_limit     = r_limit;
        n_t         = r_t;
        n_iv        = r_iv;
        n_count     = r_count;
        n_ndef      = r_ndef;
        n_d         = r_d;
        n_has_pend  = r_has_pend;
        n_pend_id   = r_pend_id;

        head_we    = 1'b0;
        head_waddr = r_s;
        head_wdata = NIL;
        head_raddr = r_ws;
        next_we    = 1'b0;
        next_waddr = r_cur;
        next_wdata = NIL;
        prev_we    = 1'b0;
        prev_waddr = r_cur;
        prev_wdata = NIL;
        slot_we    = 1'b0;
        slot_wdata = r_s;
        trig_we    = 1'b0;
        trig_wdata = r_in.trigger_ms;
        ival_we    = 1'b0;
        defer_we   = 1'b0;
        div_req    = '{start: 1'b0, num: '0, den: '0};

        elapsed   = r_in.now_ms - r_base;
        ws_inc    = SW'(r_ws) + SW'(1);
        start_sum = (SW+1)'(r_start0) + (SW+1)'(r_passing);
        iv_eff    = (r_iv < 32'(prec_e)) ? 32'(prec_e) : r_iv;
        rearm     = {1'b0, r_in.now_ms} + {1'b0, iv_eff};
        step_ms   = (SIW+16)'(r_passing) * (SIW+16)'(prec_e);
        id_bad    = 32'(r_in.tmr_id) >= 32'(NUM_TIMERS);

        unique case (r_state)
            S_CLR: begin
                // sweep every slot head to empty
                head_we    = 1'b1;
                head_waddr = r_clr;
                n_clr      = r_clr + SIW'(1);
                if (r_clr == SIW'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_cur   = IW'(i_in_data.tmr_id);
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_res = '{status: STS_OK, fired: 1'b0, result_id: r_in.tmr_id,
                          fired_total: 7'd0, last: 1'b1};
                unique case (r_in.op)
                    OP_SCHEDULE: begin
                        if (id_bad || r_active[r_cur]) begin
                            n_res.status = STS_BAD_ID;
                            n_state      = S_EMIT;
                        end else begin
                            trig_we         = 1'b1;
                            ival_we         = 1'b1;
                            n_active[r_cur] = 1'b1;
                            n_state         = S_H0;
                        end
                    end
                    OP_CANCEL: begin
                        if (id_bad || !r_active[r_cur]) begin
                            n_res.status = STS_BAD_ID;
                            n_state      = S_EMIT;
                        end else begin
                            n_active[r_cur] = 1'b0;
                            n_state         = S_U0;
                        end
                    end
                    OP_DISPATCH: begin
                        n_state = S_P0;
                    end
                    OP_QUERY: begin
                        div_req = '{start: 1'b1, num: DIV_NW'(r_start),
                                    den: DIV_DW'(slots_e)};
                        n_state = S_Q0;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_EMIT: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            // hook r_cur: slot = (start + (trigger - base) / precision) mod slots, or start mod slots if trigger < base
            S_H0: begin
                n_state = S_H1;
            end
            S_H1: begin
                if (trig_rdata >= r_base) begin
                    div_req = '{start: 1'b1, num: {1'b0, trig_rdata - r_base}, den: prec_e};
                    n_state = S_H2;
                end else begin
                    div_req = '{start: 1'b1, num: DIV_NW'(r_start),
                                den: DIV_DW'(slots_e)};
                    n_state = S_H3;
                end
            end
            S_H2: begin
                if (div_rsp.done) begin
                    div_req = '{start: 1'b1,
                                num: DIV_NW'(r_start) + {1'b0, div_rsp.quot[31:0]},
                                den: DIV_DW'(slots_e)};
                    n_state = S_H3;
                end
            end
            S_H3: begin
                head_raddr = div_rsp.rem[SIW-1:0];
                if (div_rsp.done) begin
                    n_s     = div_rsp.rem[SIW-1:0];
                    n_state = S_H4;
                end
            end
            S_H4: begin
                // push at the slot head
                head_we    = 1'b1;
                head_wdata = PW'(r_cur);
                slot_we    = 1'b1;
                prev_we    = 1'b1;
                next_we    = 1'b1;
                next_wdata = head_rdata;
                n_n        = head_rdata;
                if (!head_rdata[IW]) begin
                    n_state = S_H5;
                end else begin
                    n_state = (r_in.op == OP_SCHEDULE) ? S_EMIT : S_D3;
                end
            end
            S_H5: begin
                prev_we    = 1'b1;
                prev_waddr = r_n[IW-1:0];
                prev_wdata = PW'(r_cur);
                n_state    = (r_in.op == OP_SCHEDULE) ? S_EMIT : S_D3;
            end
            // unhook r_cur from its list
            S_U0: begin
                n_state = S_U1;
            end
            S_U1: begin
                n_t  = trig_rdata;
                n_iv = ival_rdata;
                if (!prev_rdata[IW]) begin
                    next_we    = 1'b1;
                    next_waddr = prev_rdata[IW-1:0];
                    next_wdata = next_rdata;
                end else begin
                    head_we    = 1'b1;
                    head_waddr = slot_rdata;
                    head_wdata = next_rdata;
                end
                if (!next_rdata[IW]) begin
                    prev_we    = 1'b1;
                    prev_waddr = next_rdata[IW-1:0];
                    prev_wdata = prev_rdata;
                end
                n_state = (r_in.op == OP_CANCEL) ? S_EMIT : S_W2;
            end
            // dispatch: time checks, then slots to pass and walk start
            S_P0: begin
                n_len   = (SW+16)'(slots_e - SW'(1)) * (SW+16)'(prec_e);
                n_limit = {1'b0, r_in.now_ms} + 33'(prec_e) * 33'(JUDGE_FACTOR);
                n_res   = '{status: STS_TIME_BACK, fired: 1'b0, result_id: 6'd0,
                            fired_total: 7'd0, last: 1'b1};
                n_state = S_P1;
            end
            S_P1: begin
                if (r_in.now_ms < r_base) begin
                    n_base  = r_in.now_ms;
                    n_state = S_EMIT;
                end else if (64'(elapsed) > 64'(r_len)) begin
                    n_base       = r_in.now_ms;
                    n_res.status = STS_JUMP;
                    n_state      = S_EMIT;
                end else begin
                    div_req = '{start: 1'b1, num: {1'b0, elapsed}, den: prec_e};
                    n_state = S_P2;
                end
            end
            S_P2: begin
                if (div_rsp.done) begin
                    n_passing = div_rsp.quot[SIW-1:0];
                    div_req   = '{start: 1'b1, num: DIV_NW'(r_start),
                                  den: DIV_DW'(slots_e)};
                    n_state   = S_P3;
                end
            end
            S_P3: begin
                if (div_rsp.done) begin
                    n_ws       = div_rsp.rem[SIW-1:0];
                    n_start0   = div_rsp.rem[SIW-1:0];
                    n_i        = '0;
                    n_count    = '0;
                    n_ndef     = '0;
                    n_has_pend = 1'b0;
                    n_state    = S_W0;
                end
            end
            // walk passed slots, taking every timer off
            S_W0: begin
                n_state = S_W1;
            end
            S_W1: begin
                if (!head_rdata[IW]) begin
                    n_cur   = head_rdata[IW-1:0];
                    n_state = S_U0;
                end else if (r_i == r_passing) begin
                    n_d     = '0;
                    n_state = (r_ndef == '0) ? S_FIN : S_D1;
                end else begin
                    n_i     = r_i + SIW'(1);
                    n_ws    = (ws_inc == slots_e) ? '0 : ws_inc[SIW-1:0];
                    n_state = S_W0;
                end
            end
            S_W2: begin
                if ({1'b0, r_t} <= r_limit) begin
                    // expired: the previous expired timer goes out now
                    if (!r_has_pend || out_free) begin
                        if (r_has_pend) begin
                            n_out = '{status: STS_OK, fired: 1'b1,
                                      result_id: 6'(r_pend_id),
                                      fired_total: 7'(r_count), last: 1'b0};
                            n_out_valid = 1'b1;
                        end
                        n_has_pend = 1'b1;
                        n_pend_id  = r_cur;
                        n_count    = r_count + CW'(1);
                        if (r_iv == 32'd0) begin
                            n_active[r_cur] = 1'b0;
                        end else begin
                            trig_we    = 1'b1;
                            trig_wdata = rearm[32] ? 32'hFFFF_FFFF : rearm[31:0];
                            defer_we   = 1'b1;
                            n_ndef     = r_ndef + CW'(1);
                        end
                        n_state = S_W0;
                    end
                end else begin
                    defer_we = 1'b1;
                    n_ndef   = r_ndef + CW'(1);
                    n_state  = S_W0;
                end
            end
            // hook again every deferred timer in order
            S_D1: begin
                n_state = S_D2;
            end
            S_D2: begin
                n_cur   = defer_rdata;
                n_state = S_H0;
            end
            S_D3: begin
                n_d     = r_d + CW'(1);
                n_state = (r_d + CW'(1) == r_ndef) ? S_FIN : S_D1;
            end
            S_FIN: begin
                if (out_free) begin
                    n_base  = r_base + 32'(step_ms);
                    n_start = (start_sum >= (SW+1)'(slots_e))
                              ? SIW'(start_sum - (SW+1)'(slots_e)) : SIW'(start_sum);
                    if (r_has_pend) begin
                        n_out = '{status: STS_OK, fired: 1'b1, result_id: 6'(r_pend_id),
                                  fired_total: 7'(r_count), last: 1'b1};
                    end else begin
                        n_out = '{status: STS_OK, fired: 1'b0, result_id: 6'd0,
                                  fired_total: 7'd0, last: 1'b1};
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            // query: first nonempty slot from the start slot
            S_Q0: begin
                if (div_rsp.done) begin
                    n_ws    = div_rsp.rem[SIW-1:0];
                    n_i     = '0;
                    n_state = S_Q1;
                end
            end
            S_Q1: begin
                n_state = S_Q2;
            end
            S_Q2: begin
                if (!head_rdata[IW]) begin
                    n_res = '{status: STS_OK, fired: 1'b0,
                              result_id: 6'(head_rdata[IW-1:0]),
                              fired_total: 7'd0, last: 1'b1};
                    n_state = S_EMIT;
                end else if (r_i == SIW'(slots_e - SW'(1))) begin
                    n_res = '{status: STS_NONE, fired: 1'b0, result_id: 6'd0,
                              fired_total: 7'd0, last: 1'b1};
                    n_state = S_EMIT;
                end else begin
                    n_i     = r_i + SIW'(1);
                    n_ws    = (ws_inc == slots_e) ? '0 : ws_inc[SIW-1:0];
                    n_state = S_Q1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_active    <= '0;
            r_base      <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
            r_has_pend  <= 1'b0;
            r_prec      <= PREC_RESET;
            r_slots     <= SLOTS_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_active    <= n_active;
            r_base      <= n_base;
            r_start     <= n_start;
            r_out_valid <= n_out_valid;
            r_has_pend  <= n_has_pend;
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_PRECISION: r_prec  <= pwdata[15:0];
                    REG_SLOTS:     r_slots <= pwdata[8:0];
                    default:       r_prec  <= r_prec;
                endcase
            end
        end
        r_in      <= n_in;
        r_cur     <= n_cur;
        r_res     <= n_res;
        r_out     <= n_out;
        r_s       <= n_s;
        r_n       <= n_n;
        r_ws      <= n_ws;
        r_i       <= n_i;
        r_passing <= n_passing;
        r_start0  <= n_start0;
        r_len     <= n_len;
        r_limit   <= n_limit;
        r_t       <= n_t;
        r_iv      <= n_iv;
        r_count   <= n_count;
        r_ndef    <= n_ndef;
        r_d       <= n_d;
        r_pend_id <= n_pend_id;
    end

    // config read back
    assign prdata = (paddr[2] == REG_SLOTS) ? {23'd0, r_slots} : {16'd0, r_prec};
    assign pready = 1'b1;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule
